@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the median filter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, skipped while reset is high.
`define MFEP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check on every rising edge, including the reset cycles.
`define MFEP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ sv/mfep_pkg.sv @@
// ----------------------------------------------------------------------------
// mfep_pkg
// Types and constants shared by the median filter and its sorting cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mfep_pkg;

  localparam int SAMPLE_W = 32;   // sample and median width
  localparam int HALF_W   = 3;    // half window register width
  localparam int SPAN_W   = 4;    // holds 2h, up to 14
  localparam int AGE_W    = 6;    // signed age offset c + d - h

  localparam logic [HALF_W-1:0] HALF_RESET = 3'd2;

  // What one sorting cell hands to the next cell down the chain.
  typedef struct packed {
    logic                       big;  // holds a value above the key, or is empty
    logic                       vld;
    logic signed [SAMPLE_W-1:0] val;
  } link_t;

endpackage

`default_nettype wire

@@ sv/mfep_sort_cell.sv @@
// ----------------------------------------------------------------------------
// mfep_sort_cell
// One cell of the insertion sorting chain: keeps one value in ascending order.
// ----------------------------------------------------------------------------
`default_nettype none

module mfep_sort_cell
  import mfep_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clear,
  input  wire logic                       insert,
  input  wire logic signed [SAMPLE_W-1:0] key,
  input  wire link_t                      up,
  output link_t                           down
);

  logic                       vld;
  logic signed [SAMPLE_W-1:0] val;
  logic                       big;

  // Empty cells count as larger than any key, so the big flags form 0..0 1..1.
  assign big  = !vld || (val > key);
  assign down = '{big: big, vld: vld, val: val};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (clear) begin
      vld <= 1'b0;
    end else if (insert && big) begin
      vld <= up.big ? up.vld : 1'b1;
    end
  end

  // First big cell takes the key, the ones after it shift down by one.
  always_ff @(posedge clk) begin
    if (insert && big) begin
      val <= up.big ? up.val : key;
    end
  end

endmodule

`default_nettype wire

@@ sv/median_filter_edge_padded.sv @@
// ----------------------------------------------------------------------------
// median_filter_edge_padded
// Sliding-window median with replicate padding at both ends of a sequence.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one signed sample per transfer, is_final
// marks the last sample of a sequence. Output channel (out_valid/out_stall):
// median_value with end_of_run set on the result for the final position.
// cfg_wr_en/cfg_wr_data set the half window h (window 2h+1, h limited to
// (MAX_WINDOW-1)/2); write it only while the block is idle.
// A sample that produces no result is taken and the block stays idle. Each
// result is made in steps: the window is fed one value per cycle into a chain
// of insertion cells (load step), a flush step lets the last value settle, and
// a pick step copies the middle cell into the output register. A final sample
// yields up to h+1 results, one after another. The next sample is taken as
// soon as the last result of the current one sits in the output register.
// A stalled result holds in the output register; the chain waits in its pick
// step until the register is free. Reset empties the sequence, sets h to 2
// and leaves the block idle and ready.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_edge_padded
  import mfep_pkg::*;
#(
  parameter int MAX_WINDOW = 15
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [HALF_W-1:0]          cfg_wr_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                       is_final,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      median_value,
  output logic                            end_of_run
);

  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int HMAX = (MAX_WINDOW - 1) / 2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_PICK  = 4'b1000
  } state_t;

  state_t                     state, state_next;
  logic [HALF_W-1:0]          half_width;
  logic [HALF_W-1:0]          h_eff;
  logic [HALF_W-1:0]          h_cur;
  logic [HALF_W-1:0]          ctr, ctr_next;
  logic                       fin_cur;
  logic [CW-1:0]              fill, fill_new, wfill;
  logic [SPAN_W-1:0]          dpos, dpos_next;
  logic signed [SAMPLE_W-1:0] hist [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] key;
  logic                       key_vld, key_vld_next;
  logic signed [AGE_W-1:0]    age;
  logic [AW-1:0]              rd_idx;
  logic                       accept, slot_free, capture, sort_clear;
  link_t                      links [MAX_WINDOW + 1];

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign slot_free = !out_valid || !out_stall;
  assign capture   = (state == ST_PICK) && slot_free;

  assign h_eff    = (32'(half_width) > HMAX) ? HALF_W'(HMAX) : half_width;
  assign fill_new = (32'(fill) < MAX_WINDOW) ? fill + 1'b1 : fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= HALF_RESET;
    end else if (cfg_wr_en) begin
      half_width <= cfg_wr_data;
    end
  end

  // History line, newest at index 0.
  always_ff @(posedge clk) begin
    if (accept) begin
      hist[0] <= sample;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept) begin
      fill <= is_final ? '0 : fill_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_cur   <= h_eff;
      fin_cur <= is_final;
      wfill   <= fill_new;
    end
  end

  // Age of the window value at offset dpos, clamped to the written samples.
  always_comb begin
    age = $signed(AGE_W'(ctr)) + $signed(AGE_W'(dpos)) - $signed(AGE_W'(h_cur));
    if (age < 0) begin
      rd_idx = '0;
    end else if (age >= $signed(AGE_W'(wfill))) begin
      rd_idx = AW'(wfill - 1'b1);
    end else begin
      rd_idx = AW'(age);
    end
  end

  always_comb begin
    state_next   = state;
    ctr_next     = ctr;
    dpos_next    = dpos;
    key_vld_next = 1'b0;
    sort_clear   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_final) begin
            ctr_next   = (32'(fill_new) > 32'(h_eff)) ? h_eff : HALF_W'(fill_new - 1'b1);
            state_next = ST_LOAD;
            sort_clear = 1'b1;
          end else if (32'(fill_new) > 32'(h_eff)) begin
            ctr_next   = h_eff;
            state_next = ST_LOAD;
            sort_clear = 1'b1;
          end
          dpos_next = '0;
        end
      end
      ST_LOAD: begin
        key_vld_next = 1'b1;
        if (dpos == {h_cur, 1'b0}) begin
          dpos_next  = '0;
          state_next = ST_FLUSH;
        end else begin
          dpos_next = dpos + 1'b1;
        end
      end
      ST_FLUSH: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        if (slot_free) begin
          if (fin_cur && (ctr != '0)) begin
            ctr_next   = ctr - 1'b1;
            sort_clear = 1'b1;
            state_next = ST_LOAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      key_vld <= 1'b0;
      dpos    <= '0;
      ctr     <= '0;
    end else begin
      state   <= state_next;
      key_vld <= key_vld_next;
      dpos    <= dpos_next;
      ctr     <= ctr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      key <= hist[rd_idx];
    end
  end

  // Insertion sorting chain.
  assign links[0] = '{big: 1'b0, vld: 1'b0, val: '0};

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    mfep_sort_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .clear  (sort_clear),
      .insert (key_vld),
      .key    (key),
      .up     (links[g]),
      .down   (links[g+1])
    );
  end

  // Output register: hold while stalled, drop valid after the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (capture) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      median_value <= links[32'(AW'(h_cur)) + 1].val;
      end_of_run   <= fin_cur && (ctr == '0);
    end
  end

endmodule

`default_nettype wire

@@ sv/mfep_checker.sv @@
// ----------------------------------------------------------------------------
// mfep_checker
// Port-level checks on the median filter, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mfep_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] median_value,
  input wire logic        end_of_run
);

  // A stalled result stays offered.
  `MFEP_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid)

  // A stalled result keeps its payload.
  `MFEP_ASSERT(a_out_stable, clk, rst, out_valid && out_stall |=> $stable(median_value) && $stable(end_of_run))

  // Reset leaves no result pending.
  `MFEP_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !out_valid)

  // Reset leaves the block ready for a sample.
  `MFEP_ASSERT_ALWAYS(a_rst_ready, clk, rst |=> !in_stall)

  // A sample taken in one cycle cannot be answered in the next: the window
  // must first pass through the sorting chain.
  `MFEP_ASSERT(a_min_latency, clk, rst,
    in_valid && !in_stall && !out_valid |=> !out_valid)

endmodule

bind median_filter_edge_padded mfep_checker u_mfep_checker (.*);

`default_nettype wire

@@ bench/median_filter_edge_padded_tb.sv @@
// ----------------------------------------------------------------------------
// median_filter_edge_padded_tb
// Self-checking bench for the edge-padded sliding median. It drives sample
// sequences through the valid/stall channels and writes the half window
// between sequences and mid-sequence. It predicts every median and run-end
// flag, and compares each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module median_filter_edge_padded_tb
  import mfep_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_MAX  = 15;
  localparam int HALF_LIMIT  = (WINDOW_MAX - 1) / 2;
  localparam int MAX_PACE    = 17;      // longest per-item gap or stall
  localparam int SETTLE      = 40;      // cycles for a no-result sample to finish
  localparam int HOLD_CYCLES = 200;     // long receiver hold-off
  localparam int RAND_ITEMS  = 185;
  localparam int LIMIT       = 400000;
  localparam int SHOW_MAX    = 40;      // mismatch lines printed

  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       fin;
  } median_exp_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  logic [HALF_W-1:0]          cfg_wr_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       is_final = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] median_value;
  logic                       end_of_run;

  // predictor state
  logic signed [SAMPLE_W-1:0] hist [WINDOW_MAX];
  int                         fill_cnt;
  logic [HALF_W-1:0]          half_cfg;
  median_exp_t                median_q [$];

  // pacing and bookkeeping
  int          tx_max_gap  = 0;
  int          rx_max_wait = 0;
  int          rx_wait     = 0;
  int          rx_draw;
  logic        hold_on     = 1'b0;
  int          err_cnt     = 0;
  int          checked_cnt = 0;
  int          sent_cnt    = 0;
  int          cfg_cnt     = 0;
  int          cycle_cnt   = 0;
  median_exp_t want;

  median_filter_edge_padded #(
    .MAX_WINDOW(WINDOW_MAX)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .is_final     (is_final),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .median_value (median_value),
    .end_of_run   (end_of_run)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("%0t: timeout with %0d medians outstanding", $time, median_q.size());
      $display("median_filter_edge_padded_tb: errors");
      $finish;
    end
  end

  // Median of the padded window centred `center` samples back from the newest.
  function automatic logic signed [SAMPLE_W-1:0] window_median(int center, int h);
    logic signed [SAMPLE_W-1:0] win [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] key;
    int age, n, d, j, k;
    n = 0;
    for (d = -h; d <= h; d++) begin
      age = center + d;
      if (age < 0) age = 0;
      if (age > fill_cnt - 1) age = fill_cnt - 1;
      if (age < 0) age = 0;
      if (age > WINDOW_MAX - 1) age = WINDOW_MAX - 1;
      win[n] = hist[age];
      n++;
    end
    for (k = 1; k < n; k++) begin
      key = win[k];
      j = k - 1;
      while (j >= 0 && win[j] > key) begin
        win[j + 1] = win[j];
        j--;
      end
      win[j + 1] = key;
    end
    return win[h];
  endfunction

  // Append one expected result at the tail of the queue.
  function automatic void queue_median(logic signed [SAMPLE_W-1:0] value, logic fin);
    median_exp_t item;
    item.value = value;
    item.fin   = fin;
    median_q   = {median_q, item};
  endfunction

  function automatic void predict_transfer(logic signed [SAMPLE_W-1:0] value, logic fin);
    int h, c, a;
    h = (half_cfg < HALF_LIMIT) ? int'(half_cfg) : HALF_LIMIT;
    for (a = WINDOW_MAX - 1; a > 0; a--) hist[a] = hist[a - 1];
    hist[0] = value;
    if (fill_cnt < WINDOW_MAX) fill_cnt++;
    if (!fin) begin
      if (fill_cnt > h) queue_median(window_median(h, h), 1'b0);
    end else begin
      // flush every pending position, oldest first
      c = (fill_cnt > h) ? h : fill_cnt - 1;
      while (c >= 0) begin
        queue_median(window_median(c, h), c == 0);
        c--;
      end
      fill_cnt = 0;
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return $urandom_range(0, 1) ? '0 : '1;
      3, 4:    return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [HALF_W-1:0] draw_half();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return HALF_W'(HALF_LIMIT);
      default: return $urandom_range(0, HALF_LIMIT);
    endcase
  endfunction

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic fin);
    int gap;
    gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    is_final <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_transfer(value, fin);
    sent_cnt++;
  endtask

  task automatic send_run(input int len);
    int i;
    for (i = 0; i < len; i++) send_sample(draw_sample(), i == len - 1);
  endtask

  // Drop valid, wait for every predicted median, then let the block settle.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (median_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_half_width(input logic [HALF_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    half_cfg = value;
    cfg_cnt++;
  endtask

  task automatic set_pacing();
    tx_max_gap  = ($urandom_range(0, 2) == 0) ? 0 : MAX_PACE;
    rx_max_wait = ($urandom_range(0, 2) == 0) ? 0 : MAX_PACE;
  endtask

  // Receiver: draw a stall length per result; hold_on forces a long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else if (hold_on) begin
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      rx_draw = (rx_max_wait == 0) ? 0 : $urandom_range(0, rx_max_wait);
      out_stall <= (rx_draw > 0);
      rx_wait   <= (rx_draw > 0) ? rx_draw - 1 : 0;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait   <= rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (median_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= SHOW_MAX)
          $display("%0t: unexpected result: expected none, actual median %0d end %0b",
                   $time, median_value, end_of_run);
      end else begin
        want = median_q.pop_front();
        checked_cnt++;
        if (median_value !== want.value) begin
          err_cnt++;
          if (err_cnt <= SHOW_MAX)
            $display("%0t: median_value: expected %0d, actual %0d",
                     $time, want.value, median_value);
        end
        if (end_of_run !== want.fin) begin
          err_cnt++;
          if (err_cnt <= SHOW_MAX)
            $display("%0t: end_of_run: expected %0b, actual %0b",
                     $time, want.fin, end_of_run);
        end
      end
    end
  end

  // Default window: single-sample runs at both extremes, then a mixed run.
  task automatic test_reset_defaults();
    send_sample(S_MIN, 1'b1);
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(SAMPLE_W'(1), 1'b1);
    wait_quiet();
  endtask

  // Narrowest and widest windows, the wide one longer than its run.
  task automatic test_window_extremes();
    write_half_width('0);
    send_sample(S_MAX, 1'b0);
    send_sample(-SAMPLE_W'(5), 1'b0);
    send_sample(S_MIN, 1'b1);
    wait_quiet();
    write_half_width(HALF_W'(HALF_LIMIT));
    send_sample(SAMPLE_W'(3), 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(-SAMPLE_W'(2), 1'b1);
    wait_quiet();
  endtask

  // Resize the window halfway through a run.
  task automatic test_midstream_resize();
    write_half_width(HALF_W'(1));
    send_sample(SAMPLE_W'(10), 1'b0);
    send_sample(-SAMPLE_W'(10), 1'b0);
    send_sample(SAMPLE_W'(7), 1'b0);
    wait_quiet();
    write_half_width(HALF_W'(3));
    send_sample(S_MAX, 1'b0);
    send_sample(SAMPLE_W'(0), 1'b1);
    wait_quiet();
  endtask

  // Hold the output off for a long stretch while samples keep coming.
  task automatic test_backpressure();
    write_half_width(HALF_W'(3));
    tx_max_gap  = 0;
    rx_max_wait = 0;
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
      send_run(16);
    join
    wait_quiet();
  endtask

  task automatic test_random_streams();
    int done_items, len, i;
    done_items = 0;
    while (done_items < RAND_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_quiet();
        write_half_width(draw_half());
      end
      set_pacing();
      case ($urandom_range(0, 9))
        0:       len = $urandom_range(1, 3);
        1, 2:    len = $urandom_range(13, 30);
        default: len = $urandom_range(1, 12);
      endcase
      for (i = 0; i < len; i++) begin
        if (i == len / 2 && i > 0 && $urandom_range(0, 7) == 0) begin
          wait_quiet();
          write_half_width(draw_half());
        end
        send_sample(draw_sample(), i == len - 1);
      end
      done_items += len;
    end
    wait_quiet();
  endtask

  initial begin
    for (int a = 0; a < WINDOW_MAX; a++) hist[a] = '0;
    fill_cnt = 0;
    half_cfg = HALF_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_window_extremes();
    test_midstream_resize();
    test_backpressure();
    test_random_streams();

    $display("run covered %0d samples and %0d checked medians over %0d window writes",
             sent_cnt, checked_cnt, cfg_cnt);
    if (err_cnt == 0) begin
      $display("median_filter_edge_padded_tb: clean");
    end else begin
      $display("mismatches: %0d", err_cnt);
      $display("median_filter_edge_padded_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+sv
sv/mfep_pkg.sv
sv/mfep_sort_cell.sv
sv/median_filter_edge_padded.sv
sv/mfep_checker.sv
bench/median_filter_edge_padded_tb.sv
